// File: rtl/trp_pkg.sv
`timescale 1ns / 1ps
package trp_pkg;

  typedef enum logic [5:0] {
    PH_FIRST    = 6'd0,
    PH_INSN     = 6'd1,
    PH_H_FLAGS  = 6'd2,
    PH_H_FLAGS2 = 6'd3,
    PH_H_FLAGS3 = 6'd4,
    PH_H_HDRF   = 6'd5,
    PH_H_MAGIC  = 6'd6,
    PH_H_VER    = 6'd7,
    PH_H_IAR    = 6'd8,
    PH_H_RADIX  = 6'd9,
    PH_H_RPN    = 6'd10,
    PH_H_PSIZE  = 6'd11,
    PH_H_PTCR   = 6'd12,
    PH_H_LPID   = 6'd13,
    PH_H_PID    = 6'd14,
    PH_H_CLEN   = 6'd15,
    PH_H_CMT    = 6'd16,
    PH_H_END    = 6'd17,
    PH_R_FLAGS  = 6'd18,
    PH_R_FLAGS2 = 6'd19,
    PH_R_FLAGS3 = 6'd20,
    PH_R_CHECK  = 6'd21,
    PH_R_NODE   = 6'd22,
    PH_R_TERM   = 6'd23,
    PH_R_PROC   = 6'd24,
    PH_R_DADDR  = 6'd25,
    PH_R_DRADIX = 6'd26,
    PH_R_DRPN   = 6'd27,
    PH_R_IAR    = 6'd28,
    PH_R_IRADIX = 6'd29,
    PH_R_IRPN   = 6'd30,
    PH_R_REGCNT = 6'd31,
    PH_R_REGS   = 6'd32,
    PH_R_SEQRPN = 6'd33,
    PH_R_ERR    = 6'd34,
    PH_R_SEQPS  = 6'd35,
    PH_R_IPS    = 6'd36,
    PH_R_DPS    = 6'd37,
    PH_R_END    = 6'd38
  } phase_t;

  typedef enum logic [2:0] {
    ST_INSN     = 3'd0,
    ST_HDR_OK   = 3'd1,
    ST_HDR_BAD  = 3'd2,
    ST_FLAGS    = 3'd3,
    ST_RADIX    = 3'd4
  } status_t;

  localparam logic [31:0] VSX_VERSION = 32'h0700_0000;
  localparam logic [15:0] PF_NODE  = 16'h4000;
  localparam logic [15:0] PF_TERM  = 16'h2000;
  localparam logic [15:0] PF_PROC  = 16'h1000;
  localparam logic [15:0] PF_DADDR = 16'h0800;
  localparam logic [15:0] PF_DRPN  = 16'h0200;
  localparam logic [15:0] PF_IAR   = 16'h0040;
  localparam logic [15:0] PF_IRPN  = 16'h0010;
  localparam logic [15:0] PF_REGS  = 16'h0008;
  localparam logic [15:0] PF_EXT   = 16'h0001;
  localparam logic [15:0] PF_BAD   = 16'h05A6;
  localparam logic [15:0] EF_SEQRPN = 16'h4000;
  localparam logic [15:0] EF_ERR   = 16'h1000;
  localparam logic [15:0] EF_IPS   = 16'h0200;
  localparam logic [15:0] EF_DPS   = 16'h0100;
  localparam logic [15:0] EF_SEQPS = 16'h0020;
  localparam logic [15:0] EF_HDR   = 16'h0002;
  localparam logic [15:0] EF_EXT2  = 16'h0001;
  localparam logic [15:0] EF_BAD   = 16'hACDC;
  localparam logic [15:0] XF_PTCR  = 16'h0080;
  localparam logic [15:0] XF_LPID  = 16'h0040;
  localparam logic [15:0] XF_PID   = 16'h0020;
  localparam logic [15:0] HF_MAGIC = 16'h8000;
  localparam logic [15:0] HF_VER   = 16'h4000;
  localparam logic [15:0] HF_IAR   = 16'h2000;
  localparam logic [15:0] HF_RPN   = 16'h0800;
  localparam logic [15:0] HF_PSIZE = 16'h0040;
  localparam logic [15:0] HF_CMT   = 16'h0002;
  localparam logic [15:0] HF_BAD   = 16'h17BD;

  // Register trace count byte weights, by byte index
  function automatic logic [4:0] reg_weight(input logic [3:0] idx, input logic vsx);
    logic [4:0] w;
    w = 5'd0;
    if (vsx) begin
      case (idx)
        4'd0, 4'd1, 4'd5, 4'd6: w = 5'd9;
        4'd2, 4'd3, 4'd7, 4'd8: w = 5'd18;
        4'd4, 4'd9:             w = 5'd10;
        default:                w = 5'd0;
      endcase
    end else begin
      case (idx)
        4'd0, 4'd1, 4'd4, 4'd5: w = 5'd9;
        4'd2, 4'd6:             w = 5'd18;
        4'd3, 4'd7:             w = 5'd10;
        default:                w = 5'd0;
      endcase
    end
    return w;
  endfunction

  // Result of one record, as handed to the output stage
  typedef struct packed {
    logic [16:0] record_bytes;
    logic        term_valid;
    logic [7:0]  end_code;
    logic [7:0]  end_node;
    logic        node_valid;
    logic [7:0]  node_id;
    logic        data_addr_valid;
    logic [63:0] data_addr;
    logic [31:0] insn_word;
    logic [63:0] insn_addr;
    logic [2:0]  status;
  } result_t;

endpackage

// File: rtl/trace_record_parser.sv
`timescale 1ns / 1ps
// out_tvalid is registered; it rises at the clock edge that takes a record's last byte.
// Throughput: one byte per cycle; the output register frees the input side,
// so in_tready drops only when a result is held and not taken.
// Reset (rst_n low, synchronous): parser awaits the header instruction word,
// addresses, version and halt flag clear. After an error result it drops bytes.
module trace_record_parser #(
  parameter int RADIX_LEVELS = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // byte_req[7:0]
  output logic         out_tvalid,
  input  logic         out_tready,
  // status[2:0], insn_addr[66:3], insn_word[98:67], data_addr[162:99],
  // data_addr_valid[163], node_id[171:164], node_valid[172], end_node[180:173],
  // end_code[188:181], term_valid[189], record_bytes[206:190], zero pad
  output logic [207:0] out_tdata
);

  trp_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  fcnt_r, fcnt_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [16:0] skip_r, skip_nxt;
  logic [15:0] pf_r, pf_nxt, ef_r, ef_nxt, xf_r, xf_nxt, hf_r, hf_nxt;
  logic [63:0] cur_r, cur_nxt, nxt_addr_r, nxt_addr_nxt, daddr_r, daddr_nxt;
  logic [31:0] ver_r, ver_nxt, insn_r, insn_nxt;
  logic [23:0] nt_r, nt_nxt;
  logic [16:0] rlen_r, rlen_nxt;
  logic        halt_r, halt_nxt;
  trp_pkg::result_t res_r, res_nxt;
  logic        ovalid_r, ovalid_nxt;

  logic        take, vsx;
  logic        sk_done;
  logic [2:0]  sk_status;
  trp_pkg::phase_t sk_phase, sk_start;
  logic [16:0] sk_len;
  logic [63:0] acc_sk;
  logic [15:0] pf_sk, ef_sk, xf_sk, hf_sk;

  assign in_tready = !ovalid_r || out_tready;
  assign take = in_tvalid && in_tready;
  assign vsx = ver_r >= trp_pkg::VSX_VERSION;

  // Accumulated field and flag words as seen once the current byte is taken, and the phase the seek starts from
  always_comb begin
    logic [12:0] wprod;
    wprod = 13'(in_tdata) * 13'(trp_pkg::reg_weight(fcnt_r, vsx));
    acc_sk = acc_r;
    if (take && !halt_r) begin
      if (phase_r == trp_pkg::PH_R_REGCNT) acc_sk = acc_r + 64'(wprod);
      else acc_sk = {acc_r[55:0], in_tdata};
    end
    pf_sk = pf_r; ef_sk = ef_r; xf_sk = xf_r; hf_sk = hf_r;
    case (phase_r)
      trp_pkg::PH_H_FLAGS, trp_pkg::PH_R_FLAGS:   pf_sk = acc_sk[15:0];
      trp_pkg::PH_H_FLAGS2, trp_pkg::PH_R_FLAGS2: ef_sk = acc_sk[15:0];
      trp_pkg::PH_H_FLAGS3, trp_pkg::PH_R_FLAGS3: xf_sk = acc_sk[15:0];
      trp_pkg::PH_H_HDRF:                         hf_sk = acc_sk[15:0];
      default: ;
    endcase
    sk_start = trp_pkg::phase_t'(6'(phase_r) + 6'd1);
    if (phase_r == trp_pkg::PH_FIRST) begin
      sk_start = trp_pkg::PH_H_FLAGS;
    end else if (phase_r == trp_pkg::PH_INSN) begin
      sk_start = (acc_sk[31:0] == 32'd0) ? trp_pkg::PH_H_FLAGS : trp_pkg::PH_R_FLAGS;
    end
  end

  trp_seek #(.RADIX_LEVELS(RADIX_LEVELS)) u_seek (
    .start_phase(sk_start), .pf(pf_sk), .ef(ef_sk), .xf(xf_sk), .hf(hf_sk),
    .vsx(vsx), .accum(acc_sk), .done(sk_done), .status(sk_status),
    .next_phase(sk_phase), .next_len(sk_len)
  );

  // Byte step: accumulate, close field, seek next field, build result
  always_comb begin
    logic [63:0] v;
    logic        fin;
    logic [2:0]  err;
    phase_nxt = phase_r; fcnt_nxt = fcnt_r; acc_nxt = acc_r; skip_nxt = skip_r;
    pf_nxt = pf_r; ef_nxt = ef_r; xf_nxt = xf_r; hf_nxt = hf_r;
    cur_nxt = cur_r; nxt_addr_nxt = nxt_addr_r; daddr_nxt = daddr_r;
    ver_nxt = ver_r; insn_nxt = insn_r; nt_nxt = nt_r; rlen_nxt = rlen_r;
    halt_nxt = halt_r; res_nxt = res_r; ovalid_nxt = ovalid_r && !out_tready;
    fin = 1'b0; err = 3'd0; v = 64'd0;
    if (take && !halt_r) begin
      if (rlen_r != 17'h1FFFF) rlen_nxt = rlen_r + 17'd1;
      acc_nxt = acc_sk;
      if (fcnt_r != 4'd15) fcnt_nxt = fcnt_r + 4'd1;
      if (skip_r != 17'd0) skip_nxt = skip_r - 17'd1;
      fin = (skip_nxt == 17'd0);
      v = acc_sk;
    end
    if (fin) begin
      // Act on the completed field
      case (phase_r)
        trp_pkg::PH_FIRST: begin
          insn_nxt = v[31:0];
          if (v[31:0] != 32'd0) err = trp_pkg::ST_HDR_BAD;
        end
        trp_pkg::PH_INSN: insn_nxt = v[31:0];
        trp_pkg::PH_H_FLAGS: begin
          pf_nxt = v[15:0];
          if (v[15:0] != trp_pkg::PF_EXT) err = trp_pkg::ST_HDR_BAD;
        end
        trp_pkg::PH_H_FLAGS2: begin
          ef_nxt = v[15:0];
          if ((v[15:0] & trp_pkg::EF_HDR) == 0 ||
              (v[15:0] & ~(trp_pkg::EF_HDR | trp_pkg::EF_EXT2)) != 0)
            err = trp_pkg::ST_HDR_BAD;
        end
        trp_pkg::PH_H_FLAGS3, trp_pkg::PH_R_FLAGS3: xf_nxt = v[15:0];
        trp_pkg::PH_H_HDRF: begin
          hf_nxt = v[15:0];
          if ((v[15:0] & trp_pkg::HF_BAD) != 0) err = trp_pkg::ST_HDR_BAD;
        end
        trp_pkg::PH_H_VER: ver_nxt = v[31:0];
        trp_pkg::PH_H_IAR, trp_pkg::PH_R_IAR: nxt_addr_nxt = v;
        trp_pkg::PH_R_FLAGS: pf_nxt = v[15:0];
        trp_pkg::PH_R_FLAGS2: ef_nxt = v[15:0];
        trp_pkg::PH_R_NODE: nt_nxt = nt_r | {v[7:0], 16'd0};
        trp_pkg::PH_R_TERM: nt_nxt = nt_r | {8'd0, v[15:0]};
        trp_pkg::PH_R_DADDR: daddr_nxt = v;
        default: ;
      endcase
      if (err == 3'd0 && !sk_done) begin
        phase_nxt = sk_phase;
        skip_nxt = sk_len;
        fcnt_nxt = 4'd0;
        acc_nxt = 64'd0;
      end else begin
        // Emit a result
        res_nxt = '0;
        res_nxt.status = (err != 3'd0) ? err : sk_status;
        res_nxt.insn_addr = cur_r;
        res_nxt.insn_word = insn_nxt;
        res_nxt.record_bytes = rlen_nxt;
        ovalid_nxt = 1'b1;
        if (err != 3'd0 || sk_status >= trp_pkg::ST_HDR_BAD) begin
          halt_nxt = 1'b1;
        end else begin
          if (sk_status == trp_pkg::ST_INSN) begin
            if ((pf_nxt & trp_pkg::PF_DADDR) != 0) begin
              res_nxt.data_addr = daddr_nxt;
              res_nxt.data_addr_valid = 1'b1;
            end
            if ((pf_nxt & trp_pkg::PF_NODE) != 0) begin
              res_nxt.node_id = nt_nxt[23:16];
              res_nxt.node_valid = 1'b1;
            end
            if ((pf_nxt & trp_pkg::PF_TERM) != 0) begin
              res_nxt.end_node = nt_nxt[15:8];
              res_nxt.end_code = nt_nxt[7:0];
              res_nxt.term_valid = 1'b1;
            end
            cur_nxt = ((pf_nxt & trp_pkg::PF_IAR) != 0) ? nxt_addr_nxt : cur_r + 64'd4;
          end else begin
            cur_nxt = nxt_addr_nxt;
          end
          // Start the next record
          phase_nxt = trp_pkg::PH_INSN;
          fcnt_nxt = 4'd0; acc_nxt = 64'd0; skip_nxt = 17'd4;
          pf_nxt = 16'd0; ef_nxt = 16'd0; xf_nxt = 16'd0; hf_nxt = 16'd0;
          nxt_addr_nxt = cur_nxt; insn_nxt = 32'd0; daddr_nxt = 64'd0;
          nt_nxt = 24'd0; rlen_nxt = 17'd0;
        end
      end
    end
  end

  // State and output registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= trp_pkg::PH_FIRST; fcnt_r <= 4'd0; acc_r <= 64'd0; skip_r <= 17'd4;
      pf_r <= 16'd0; ef_r <= 16'd0; xf_r <= 16'd0; hf_r <= 16'd0;
      cur_r <= 64'd0; nxt_addr_r <= 64'd0; daddr_r <= 64'd0;
      ver_r <= 32'd0; insn_r <= 32'd0; nt_r <= 24'd0; rlen_r <= 17'd0;
      halt_r <= 1'b0; ovalid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt; fcnt_r <= fcnt_nxt; acc_r <= acc_nxt; skip_r <= skip_nxt;
      pf_r <= pf_nxt; ef_r <= ef_nxt; xf_r <= xf_nxt; hf_r <= hf_nxt;
      cur_r <= cur_nxt; nxt_addr_r <= nxt_addr_nxt; daddr_r <= daddr_nxt;
      ver_r <= ver_nxt; insn_r <= insn_nxt; nt_r <= nt_nxt; rlen_r <= rlen_nxt;
      halt_r <= halt_nxt; ovalid_r <= ovalid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = {1'b0, res_r};

endmodule

// File: rtl/trp_seek.sv
`timescale 1ns / 1ps
// Picks the next present field from a candidate phase. Each phase is
// examined in parallel; a priority search finds the first one that
// holds bytes, raises an error or ends the header or record.
module trp_seek #(
  parameter int RADIX_LEVELS = 4
) (
  input  trp_pkg::phase_t start_phase,
  input  logic [15:0]     pf,
  input  logic [15:0]     ef,
  input  logic [15:0]     xf,
  input  logic [15:0]     hf,
  input  logic            vsx,
  input  logic [63:0]     accum,
  output logic            done,      // status to emit
  output logic [2:0]      status,
  output trp_pkg::phase_t next_phase,
  output logic [16:0]     next_len
);

  localparam logic [16:0] RADIX_BYTES = 17'(RADIX_LEVELS * 8);
  localparam int NPH = 39;

  logic [16:0] len_a [NPH];
  logic [2:0]  err_a [NPH];

  function automatic logic [16:0] rlen(input logic [1:0] host);
    return (host == 2'd0) ? RADIX_BYTES : 17'd0;
  endfunction

  // Length and error of every phase
  always_comb begin
    for (int i = 0; i < NPH; i++) begin
      len_a[i] = 17'd0;
      err_a[i] = 3'd0;
    end
    len_a[trp_pkg::PH_H_FLAGS]  = 17'd2;
    len_a[trp_pkg::PH_H_FLAGS2] = 17'd2;
    len_a[trp_pkg::PH_H_FLAGS3] = (ef & trp_pkg::EF_EXT2) != 0 ? 17'd2 : 17'd0;
    len_a[trp_pkg::PH_H_HDRF]   = 17'd2;
    len_a[trp_pkg::PH_H_MAGIC]  = (hf & trp_pkg::HF_MAGIC) != 0 ? 17'd4 : 17'd0;
    len_a[trp_pkg::PH_H_VER]    = (hf & trp_pkg::HF_VER) != 0 ? 17'd4 : 17'd0;
    len_a[trp_pkg::PH_H_IAR]    = (hf & trp_pkg::HF_IAR) != 0 ? 17'd8 : 17'd0;
    if ((hf & trp_pkg::HF_RPN) != 0 && (ef & trp_pkg::EF_EXT2) != 0) begin
      if (xf[9:8] == 2'd0) err_a[trp_pkg::PH_H_RADIX] = trp_pkg::ST_RADIX;
      else len_a[trp_pkg::PH_H_RADIX] = rlen(xf[11:10]);
    end
    len_a[trp_pkg::PH_H_RPN]   = (hf & trp_pkg::HF_RPN) != 0 ? 17'd4 : 17'd0;
    len_a[trp_pkg::PH_H_PSIZE] = (hf & trp_pkg::HF_PSIZE) != 0 ? 17'd1 : 17'd0;
    len_a[trp_pkg::PH_H_PTCR]  = (xf & trp_pkg::XF_PTCR) != 0 ? 17'd8 : 17'd0;
    len_a[trp_pkg::PH_H_LPID]  = (xf & trp_pkg::XF_LPID) != 0 ? 17'd8 : 17'd0;
    len_a[trp_pkg::PH_H_PID]   = (xf & trp_pkg::XF_PID) != 0 ? 17'd4 : 17'd0;
    len_a[trp_pkg::PH_H_CLEN]  = (hf & trp_pkg::HF_CMT) != 0 ? 17'd2 : 17'd0;
    len_a[trp_pkg::PH_H_CMT]   = (hf & trp_pkg::HF_CMT) != 0 ? {1'b0, accum[15:0]} : 17'd0;
    len_a[trp_pkg::PH_R_FLAGS]  = 17'd2;
    len_a[trp_pkg::PH_R_FLAGS2] = (pf & trp_pkg::PF_EXT) != 0 ? 17'd2 : 17'd0;
    len_a[trp_pkg::PH_R_FLAGS3] = (ef & trp_pkg::EF_EXT2) != 0 ? 17'd2 : 17'd0;
    if ((pf & trp_pkg::PF_BAD) != 0 || (ef & trp_pkg::EF_BAD) != 0)
      err_a[trp_pkg::PH_R_CHECK] = trp_pkg::ST_FLAGS;
    len_a[trp_pkg::PH_R_NODE]  = (pf & trp_pkg::PF_NODE) != 0 ? 17'd1 : 17'd0;
    len_a[trp_pkg::PH_R_TERM]  = (pf & trp_pkg::PF_TERM) != 0 ? 17'd2 : 17'd0;
    len_a[trp_pkg::PH_R_PROC]  = (pf & trp_pkg::PF_PROC) != 0 ? 17'd1 : 17'd0;
    len_a[trp_pkg::PH_R_DADDR] = (pf & trp_pkg::PF_DADDR) != 0 ? 17'd8 : 17'd0;
    if ((pf & trp_pkg::PF_DRPN) != 0 && (ef & trp_pkg::EF_EXT2) != 0) begin
      if (xf[13:12] == 2'd0) err_a[trp_pkg::PH_R_DRADIX] = trp_pkg::ST_RADIX;
      else len_a[trp_pkg::PH_R_DRADIX] = rlen(xf[15:14]);
    end
    len_a[trp_pkg::PH_R_DRPN] = (pf & trp_pkg::PF_DRPN) != 0 ? 17'd4 : 17'd0;
    len_a[trp_pkg::PH_R_IAR]  = (pf & trp_pkg::PF_IAR) != 0 ? 17'd8 : 17'd0;
    if ((pf & trp_pkg::PF_IRPN) != 0 && (ef & trp_pkg::EF_EXT2) != 0) begin
      if (xf[9:8] == 2'd0) err_a[trp_pkg::PH_R_IRADIX] = trp_pkg::ST_RADIX;
      else len_a[trp_pkg::PH_R_IRADIX] = rlen(xf[11:10]);
    end
    len_a[trp_pkg::PH_R_IRPN] = (pf & trp_pkg::PF_IRPN) != 0 ? 17'd4 : 17'd0;
    if ((pf & trp_pkg::PF_REGS) != 0)
      len_a[trp_pkg::PH_R_REGCNT] = vsx ? 17'd10 : 17'd8;
    len_a[trp_pkg::PH_R_REGS]   = (pf & trp_pkg::PF_REGS) != 0 ? accum[16:0] : 17'd0;
    len_a[trp_pkg::PH_R_SEQRPN] = (ef & trp_pkg::EF_SEQRPN) != 0 ? 17'd4 : 17'd0;
    len_a[trp_pkg::PH_R_ERR]    = (ef & trp_pkg::EF_ERR) != 0 ? 17'd1 : 17'd0;
    len_a[trp_pkg::PH_R_SEQPS]  = (ef & trp_pkg::EF_SEQPS) != 0 ? 17'd1 : 17'd0;
    len_a[trp_pkg::PH_R_IPS]    = (ef & trp_pkg::EF_IPS) != 0 ? 17'd1 : 17'd0;
    len_a[trp_pkg::PH_R_DPS]    = (ef & trp_pkg::EF_DPS) != 0 ? 17'd1 : 17'd0;
  end

  // First phase at or after the start that stops the walk
  always_comb begin
    logic found;
    found      = 1'b0;
    done       = 1'b0;
    status     = trp_pkg::ST_INSN;
    next_phase = start_phase;
    next_len   = 17'd0;
    for (int i = 0; i < NPH; i++) begin
      if (!found && 6'(i) >= start_phase) begin
        if (i == int'(trp_pkg::PH_H_END)) begin
          found = 1'b1; done = 1'b1; status = trp_pkg::ST_HDR_OK;
        end else if (i == int'(trp_pkg::PH_R_END)) begin
          found = 1'b1; done = 1'b1; status = trp_pkg::ST_INSN;
        end else if (err_a[i] != 3'd0) begin
          found = 1'b1; done = 1'b1; status = err_a[i];
        end else if (len_a[i] != 17'd0) begin
          found = 1'b1;
          next_phase = trp_pkg::phase_t'(6'(i));
          next_len = len_a[i];
        end
      end
    end
  end

endmodule
